// File: src/vthq_pkg.sv
// Shared types and constants for the versioned timer heap queue.
package vthq_pkg;

   localparam int DEADLINE_W = 63;
   localparam int TAG_W = 32;
   localparam int VER_W = 32;
   localparam int ID_W = 64;
   localparam int FIRE_W = 5;
   localparam int RESULT_CAP = 16;
   localparam int SCAN_GROUP = 16;
   localparam int SCAN_PE_W = 4;

   localparam logic [VER_W-1:0] VERSION_START = 32'd2;
   localparam logic [VER_W-1:0] VERSION_STEP = 32'd2;

   localparam logic [1:0] FUNC_SCHEDULE = 2'd0;
   localparam logic [1:0] FUNC_CANCEL = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   localparam logic [1:0] KIND_SCHEDULE = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_FIRED = 2'd2;
   localparam logic [1:0] KIND_IDLE = 2'd3;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_NOT_PENDING = 2'd1;
   localparam logic [1:0] STAT_INVALID = 2'd2;
   localparam logic [1:0] STAT_REJECTED = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_SCHED_RD,
      S_SCHED_DO,
      S_REJECT,
      S_CANCEL_RD,
      S_CANCEL_DO,
      S_CANCEL_BAD,
      S_TICK_RD,
      S_TICK_DO,
      S_TICK_END
   } state_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } chain_cmd_type;

endpackage

// File: src/vthq_ram.sv
// Generic single-write, registered-read RAM.
module vthq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: src/vthq_cell.sv
// One cell of the sorted deadline chain.
module vthq_cell
   import vthq_pkg::*;
#(
   parameter int SLOT_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  chain_cmd_type         cmd,
   input  logic [DEADLINE_W-1:0] new_deadline,
   input  logic [SLOT_W-1:0]     new_slot,
   input  logic [DEADLINE_W-1:0] left_deadline,
   input  logic [SLOT_W-1:0]     left_slot,
   input  logic                  left_valid,
   input  logic                  left_lt,
   input  logic [DEADLINE_W-1:0] right_deadline,
   input  logic [SLOT_W-1:0]     right_slot,
   input  logic                  right_valid,
   output logic [DEADLINE_W-1:0] deadline,
   output logic [SLOT_W-1:0]     slot,
   output logic                  valid,
   output logic                  lt
);
   logic [DEADLINE_W-1:0] deadline_ff, deadline_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic                  valid_ff, valid_in;

   assign lt = valid_ff && ((deadline_ff < new_deadline) ||
               ((deadline_ff == new_deadline) && (slot_ff < new_slot)));

   always_comb begin
      deadline_in = deadline_ff;
      slot_in = slot_ff;
      valid_in = valid_ff;
      if (cmd.pop) begin
         deadline_in = right_deadline;
         slot_in = right_slot;
         valid_in = right_valid;
      end else if (cmd.insert && !lt) begin
         if (left_lt) begin
            deadline_in = new_deadline;
            slot_in = new_slot;
            valid_in = 1'b1;
         end else begin
            deadline_in = left_deadline;
            slot_in = left_slot;
            valid_in = left_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      deadline_ff <= deadline_in;
      slot_ff <= slot_in;
   end

   assign deadline = deadline_ff;
   assign slot = slot_ff;
   assign valid = valid_ff;
endmodule

// File: src/vthq_chain.sv
// Row of cells holding pending entries sorted by deadline, then slot.
module vthq_chain
   import vthq_pkg::*;
#(
   parameter int CAPACITY = 256,
   parameter int SLOT_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  chain_cmd_type         cmd,
   input  logic [DEADLINE_W-1:0] new_deadline,
   input  logic [SLOT_W-1:0]     new_slot,
   output logic [DEADLINE_W-1:0] top_deadline,
   output logic [SLOT_W-1:0]     top_slot
);
   logic [DEADLINE_W-1:0] d_w [CAPACITY];
   logic [SLOT_W-1:0]     s_w [CAPACITY];
   logic                  v_w [CAPACITY];
   logic                  lt_w [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DEADLINE_W-1:0] ld, rd;
      logic [SLOT_W-1:0]     ls, rs;
      logic                  lv, llt, rv;
      if (i == 0) begin : g_first
         assign ld = '0;
         assign ls = '0;
         assign lv = 1'b0;
         assign llt = 1'b1;
      end else begin : g_mid
         assign ld = d_w[i-1];
         assign ls = s_w[i-1];
         assign lv = v_w[i-1];
         assign llt = lt_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign rd = '0;
         assign rs = '0;
         assign rv = 1'b0;
      end else begin : g_inner
         assign rd = d_w[i+1];
         assign rs = s_w[i+1];
         assign rv = v_w[i+1];
      end
      vthq_cell #(.SLOT_W(SLOT_W)) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .new_deadline  (new_deadline),
         .new_slot      (new_slot),
         .left_deadline (ld),
         .left_slot     (ls),
         .left_valid    (lv),
         .left_lt       (llt),
         .right_deadline(rd),
         .right_slot    (rs),
         .right_valid   (rv),
         .deadline      (d_w[i]),
         .slot          (s_w[i]),
         .valid         (v_w[i]),
         .lt            (lt_w[i])
      );
   end

   assign top_deadline = d_w[0];
   assign top_slot = s_w[0];
endmodule

// File: src/versioned_timer_heap_queue.sv
// Top level of the versioned deadline timer queue.
//  channel | direction | handshake          | payload
//  req     | in        | req_tvalid/tready  | tuser func, tdata fields
//  rsp     | out       | rsp_tvalid/tready  | tuser kind, tlast, tdata fields
//  csr     | in        | csr_we             | csr_wdata enable
// After reset a clearing pass sets all slot versions; no item is taken then.
// Schedule: the free-slot search scans 16-slot groups in turn, lowest free slot first.
// Cancel: reads the slot's versions, then replies; a slot out of range is answered without the read.
// Tick: removes stale top entries and fires due ones in turn, then sends a final reply.
// An item waits in place while the result register is still full.
module versioned_timer_heap_queue
   import vthq_pkg::*;
#(
   parameter int CAPACITY = 256,
   parameter int MAX_FIRES_PER_TICK = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,  // func
   input  logic [223:0] req_tdata,  // deadline_us, context_tag, cancel_task_id, now_us
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,  // result_kind
   output logic         rsp_tlast,
   output logic [103:0] rsp_tdata,  // task_id, fired_tag, status, new_earliest
   input  logic         csr_we,
   input  logic         csr_wdata
);
   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int NGROUP = (CAPACITY + SCAN_GROUP - 1) / SCAN_GROUP;
   localparam int GRP_W = (NGROUP > 1) ? $clog2(NGROUP) : 1;
   localparam int SCAN_W = GRP_W + SCAN_PE_W;
   localparam int LIMIT = (MAX_FIRES_PER_TICK < RESULT_CAP) ? MAX_FIRES_PER_TICK : RESULT_CAP;

   state_type state_ff, state_in;

   logic                  enable_ff;
   logic [DEADLINE_W-1:0] deadline_ff, now_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [ID_W-1:0]       cid_ff;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [GRP_W-1:0]      grp_ff, grp_in;
   logic [SLOT_W-1:0]     clr_ff;
   logic [CAPACITY-1:0]   busy_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [FIRE_W-1:0]     nfire_ff;
   logic                  held_valid_ff;
   logic [ID_W-1:0]       held_id_ff;
   logic [TAG_W-1:0]      held_tag_ff;

   logic                  rsp_valid_ff;
   logic [1:0]            out_kind_ff, out_status_ff;
   logic [ID_W-1:0]       out_id_ff;
   logic [TAG_W-1:0]      out_tag_ff;
   logic                  out_early_ff, out_last_ff;

   logic                  accept, out_free;
   logic                  emit, emit_early, emit_last;
   logic [1:0]            emit_kind, emit_status;
   logic [ID_W-1:0]       emit_id;
   logic [TAG_W-1:0]      emit_tag;
   logic                  busy_set, busy_clr, cnt_inc, cnt_dec, held_load, fire_inc;
   logic [SLOT_W-1:0]     busy_idx, ram_raddr, ram_waddr;
   logic                  ver_we, meta_we;
   logic [VER_W-1:0]      ver_wdata, ver_rdata, ver_use, cur_v, iss_v;
   logic [VER_W+TAG_W-1:0] meta_rdata;
   chain_cmd_type         cmd;
   logic [DEADLINE_W-1:0] top_deadline;
   logic [SLOT_W-1:0]     top_slot;

   logic [NGROUP*SCAN_GROUP-1:0] busy_pad;
   logic [SCAN_GROUP-1:0]        grp_busy;
   logic                         grp_free;
   logic [SCAN_PE_W-1:0]         grp_pe;
   logic [SCAN_W-1:0]            found;
   logic                         cancel_ok, stale_top, top_due;

   assign accept = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      busy_pad = '1;
      busy_pad[CAPACITY-1:0] = busy_ff;
   end

   assign grp_busy = busy_pad[grp_ff*SCAN_GROUP +: SCAN_GROUP];
   assign grp_free = !(&grp_busy);

   always_comb begin
      grp_pe = '0;
      for (int i = SCAN_GROUP - 1; i >= 0; i--) begin
         if (!grp_busy[i]) begin
            grp_pe = SCAN_PE_W'(i);
         end
      end
   end

   assign found = {grp_ff, grp_pe};

   assign ver_use = (ver_rdata == '0) ? VERSION_START : ver_rdata;
   assign cur_v = ver_rdata;
   assign iss_v = meta_rdata[VER_W+TAG_W-1:TAG_W];
   assign cancel_ok = busy_ff[slot_ff] && (cur_v == cid_ff[63:32]) &&
                      (iss_v == cid_ff[63:32]);
   assign stale_top = cur_v != iss_v;
   assign top_due = (top_deadline <= now_ff) && (nfire_ff < FIRE_W'(LIMIT));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == SLOT_W'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  FUNC_SCHEDULE: state_in = enable_ff ? S_SCAN : S_REJECT;
                  FUNC_CANCEL: begin
                     state_in = (req_tdata[126:95] >= 32'(CAPACITY)) ? S_CANCEL_BAD
                                                                      : S_CANCEL_RD;
                  end
                  FUNC_TICK: state_in = S_TICK_RD;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (grp_free) begin
               state_in = S_SCHED_RD;
            end else if (grp_ff == GRP_W'(NGROUP - 1)) begin
               state_in = S_REJECT;
            end
         end
         S_SCHED_RD: state_in = S_SCHED_DO;
         S_SCHED_DO: if (out_free) state_in = S_IDLE;
         S_REJECT: if (out_free) state_in = S_IDLE;
         S_CANCEL_RD: state_in = S_CANCEL_DO;
         S_CANCEL_DO: if (out_free) state_in = S_IDLE;
         S_CANCEL_BAD: if (out_free) state_in = S_IDLE;
         S_TICK_RD: state_in = (cnt_ff == '0) ? S_TICK_END : S_TICK_DO;
         S_TICK_DO: begin
            if (stale_top) begin
               state_in = S_TICK_RD;
            end else if (!top_due) begin
               state_in = S_TICK_END;
            end else if (!held_valid_ff || out_free) begin
               state_in = S_TICK_RD;
            end
         end
         S_TICK_END: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = state_ff == S_IDLE;
      emit = 1'b0;
      emit_kind = KIND_SCHEDULE;
      emit_id = '0;
      emit_tag = '0;
      emit_status = STAT_OK;
      emit_early = 1'b0;
      emit_last = 1'b1;
      busy_set = 1'b0;
      busy_clr = 1'b0;
      busy_idx = slot_ff;
      cnt_inc = 1'b0;
      cnt_dec = 1'b0;
      held_load = 1'b0;
      fire_inc = 1'b0;
      cmd = '0;
      ver_we = 1'b0;
      ver_wdata = VERSION_START;
      meta_we = 1'b0;
      ram_raddr = slot_ff;
      ram_waddr = slot_ff;
      slot_in = slot_ff;
      grp_in = grp_ff;
      case (state_ff)
         S_CLEAR: begin
            ver_we = 1'b1;
            ram_waddr = clr_ff;
         end
         S_IDLE: begin
            grp_in = '0;
            slot_in = req_tdata[95 +: SLOT_W];
         end
         S_SCAN: begin
            if (grp_free) begin
               slot_in = found[SLOT_W-1:0];
            end else begin
               grp_in = grp_ff + GRP_W'(1);
            end
         end
         S_SCHED_DO: begin
            if (out_free) begin
               emit = 1'b1;
               emit_id = {ver_use, 32'(slot_ff)};
               emit_early = (cnt_ff == '0) || (deadline_ff < top_deadline);
               ver_we = 1'b1;
               ver_wdata = ver_use;
               meta_we = 1'b1;
               busy_set = 1'b1;
               cnt_inc = 1'b1;
               cmd.insert = 1'b1;
            end
         end
         S_REJECT: begin
            emit = out_free;
            emit_status = STAT_REJECTED;
         end
         S_CANCEL_DO: begin
            if (out_free) begin
               emit = 1'b1;
               emit_kind = KIND_CANCEL;
               emit_id = cid_ff;
               emit_status = cancel_ok ? STAT_OK : STAT_NOT_PENDING;
               ver_we = cancel_ok;
               ver_wdata = cid_ff[63:32] + VERSION_STEP;
            end
         end
         S_CANCEL_BAD: begin
            emit = out_free;
            emit_kind = KIND_CANCEL;
            emit_id = cid_ff;
            emit_status = STAT_INVALID;
         end
         S_TICK_RD: begin
            ram_raddr = top_slot;
         end
         S_TICK_DO: begin
            ram_raddr = top_slot;
            ram_waddr = top_slot;
            busy_idx = top_slot;
            if (stale_top) begin
               cmd.pop = 1'b1;
               busy_clr = 1'b1;
               cnt_dec = 1'b1;
            end else if (top_due && (!held_valid_ff || out_free)) begin
               emit = held_valid_ff;
               emit_kind = KIND_FIRED;
               emit_id = held_id_ff;
               emit_tag = held_tag_ff;
               emit_last = 1'b0;
               cmd.pop = 1'b1;
               busy_clr = 1'b1;
               cnt_dec = 1'b1;
               ver_we = 1'b1;
               ver_wdata = iss_v + VERSION_STEP;
               held_load = 1'b1;
               fire_inc = 1'b1;
            end
         end
         S_TICK_END: begin
            emit = out_free;
            emit_kind = held_valid_ff ? KIND_FIRED : KIND_IDLE;
            emit_id = held_valid_ff ? held_id_ff : '0;
            emit_tag = held_valid_ff ? held_tag_ff : '0;
         end
         default: begin
         end
      endcase
   end

   vthq_ram #(.WIDTH(VER_W), .DEPTH(CAPACITY)) u_ver_ram (
      .clock(clock),
      .we   (ver_we),
      .waddr(ram_waddr),
      .wdata(ver_wdata),
      .raddr(ram_raddr),
      .rdata(ver_rdata)
   );

   vthq_ram #(.WIDTH(VER_W + TAG_W), .DEPTH(CAPACITY)) u_meta_ram (
      .clock(clock),
      .we   (meta_we),
      .waddr(ram_waddr),
      .wdata({ver_use, tag_ff}),
      .raddr(ram_raddr),
      .rdata(meta_rdata)
   );

   vthq_chain #(.CAPACITY(CAPACITY), .SLOT_W(SLOT_W)) u_chain (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .new_deadline(deadline_ff),
      .new_slot    (slot_ff),
      .top_deadline(top_deadline),
      .top_slot    (top_slot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         enable_ff <= 1'b1;
         clr_ff <= '0;
         busy_ff <= '0;
         cnt_ff <= '0;
         nfire_ff <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         grp_ff <= '0;
      end else begin
         state_ff <= state_in;
         grp_ff <= grp_in;
         if (csr_we) begin
            enable_ff <= csr_wdata;
         end
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + SLOT_W'(1);
         end
         if (busy_set) begin
            busy_ff[busy_idx] <= 1'b1;
         end else if (busy_clr) begin
            busy_ff[busy_idx] <= 1'b0;
         end
         if (cnt_inc) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (cnt_dec) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         if (accept) begin
            nfire_ff <= '0;
            held_valid_ff <= 1'b0;
         end else if (fire_inc) begin
            nfire_ff <= nfire_ff + FIRE_W'(1);
            held_valid_ff <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      slot_ff <= slot_in;
      if (accept) begin
         deadline_ff <= req_tdata[62:0];
         tag_ff <= req_tdata[94:63];
         cid_ff <= req_tdata[158:95];
         now_ff <= req_tdata[221:159];
      end
      if (held_load) begin
         held_id_ff <= {iss_v, 32'(top_slot)};
         held_tag_ff <= meta_rdata[TAG_W-1:0];
      end
      if (emit) begin
         out_kind_ff <= emit_kind;
         out_id_ff <= emit_id;
         out_tag_ff <= emit_tag;
         out_status_ff <= emit_status;
         out_early_ff <= emit_early;
         out_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = out_kind_ff;
   assign rsp_tlast = out_last_ff;
   assign rsp_tdata = {5'd0, out_early_ff, out_status_ff, out_tag_ff, out_id_ff};
endmodule

// File: src/vthq_checker.sv
// Port-level checks for the timer queue, bound to the top level.
module vthq_checker
   import vthq_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast,
   input logic [103:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SCHEDULE || rsp_tuser == KIND_CANCEL ||
      rsp_tuser == KIND_IDLE) |-> rsp_tlast)
      else $error("single reply without last");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_IDLE |-> rsp_tdata[98:0] == '0)
      else $error("empty tick carries data");

   a_early: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[98] |-> rsp_tuser == KIND_SCHEDULE &&
      rsp_tdata[97:96] == STAT_OK)
      else $error("earliest flag outside a scheduled reply");

   a_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_FIRED |-> rsp_tdata[95:64] == '0)
      else $error("tag outside a fire");
endmodule

bind versioned_timer_heap_queue vthq_checker u_vthq_checker (.*);

// File: test/tb_versioned_timer_heap_queue.sv
// Testbench for the versioned timer heap queue: directed and random items.
`timescale 1ns / 100ps

module tb_versioned_timer_heap_queue;
   import vthq_pkg::*;

   localparam int SLOTS = 256;
   localparam int FIRE_LIMIT = 16;
   localparam logic [62:0] DL_MAX = {63{1'b1}};
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  kind;
      logic [63:0] id;
      logic [31:0] tag;
      logic [1:0]  status;
      logic        earliest;
      logic        last;
   } timer_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [1:0]   req_tuser;
   logic [223:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic [103:0] rsp_tdata;
   logic         csr_we;
   logic         csr_wdata;

   timer_result_type expected_results[$];
   logic [63:0]   live_ids[$];
   int            error_count;
   logic [62:0]   sim_now;
   int            rsp_mode;

   // model state
   logic [62:0] heap_dl[SLOTS];
   logic [7:0]  heap_sl[SLOTS];
   int          heap_n;
   bit          slot_busy[SLOTS];
   logic [31:0] ver_current[SLOTS];
   logic [31:0] ver_issued[SLOTS];
   logic [31:0] slot_tag[SLOTS];
   bit          queue_enabled;

   versioned_timer_heap_queue dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic bit heap_less(int a, int b);
      if (heap_dl[a] != heap_dl[b]) return heap_dl[a] < heap_dl[b];
      return heap_sl[a] < heap_sl[b];
   endfunction

   function automatic void heap_swap(int a, int b);
      logic [62:0] d;
      logic [7:0]  s;
      d = heap_dl[a]; s = heap_sl[a];
      heap_dl[a] = heap_dl[b]; heap_sl[a] = heap_sl[b];
      heap_dl[b] = d; heap_sl[b] = s;
   endfunction

   function automatic void heap_insert(logic [62:0] dl, logic [7:0] sl);
      int i;
      int p;
      i = heap_n;
      heap_dl[i] = dl; heap_sl[i] = sl;
      heap_n++;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!heap_less(i, p)) break;
         heap_swap(i, p);
         i = p;
      end
   endfunction

   function automatic void heap_remove_top();
      int i;
      int l;
      int c;
      i = 0;
      heap_n--;
      heap_dl[0] = heap_dl[heap_n]; heap_sl[0] = heap_sl[heap_n];
      forever begin
         l = 2 * i + 1;
         if (l >= heap_n) break;
         c = l;
         if (l + 1 < heap_n && heap_less(l + 1, l)) c = l + 1;
         if (!heap_less(c, i)) break;
         heap_swap(c, i);
         i = c;
      end
   endfunction

   function automatic void add_result(logic [1:0] kind, logic [63:0] id, logic [31:0] tag,
                                      logic [1:0] status, logic earliest);
      timer_result_type r;
      r.kind = kind; r.id = id; r.tag = tag; r.status = status;
      r.earliest = earliest; r.last = 1'b0;
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic void predict_timer_results(logic [1:0] func, logic [62:0] dl,
                                                 logic [31:0] tag, logic [63:0] cid,
                                                 logic [62:0] now);
      int slot;
      int fired;
      logic [31:0] ver;
      logic earliest;
      slot = SLOTS;
      fired = 0;
      case (func)
         FUNC_SCHEDULE: begin
            if (queue_enabled)
               for (int i = 0; i < SLOTS; i++)
                  if (!slot_busy[i]) begin
                     slot = i;
                     break;
                  end
            if (slot >= SLOTS || heap_n >= SLOTS) begin
               add_result(KIND_SCHEDULE, 64'd0, 32'd0, STAT_REJECTED, 1'b0);
            end else begin
               ver = (ver_current[slot] == 0) ? VERSION_START : ver_current[slot];
               ver_current[slot] = ver;
               ver_issued[slot] = ver;
               slot_tag[slot] = tag;
               slot_busy[slot] = 1;
               earliest = (heap_n == 0) || (dl < heap_dl[0]);
               heap_insert(dl, slot[7:0]);
               add_result(KIND_SCHEDULE, {ver, 32'(slot)}, 32'd0, STAT_OK, earliest);
               live_ids.insert(live_ids.size(), {ver, 32'(slot)});
               if (live_ids.size() > 64) void'(live_ids.pop_front());
            end
         end
         FUNC_CANCEL: begin
            ver = cid[63:32];
            if (cid[31:0] >= SLOTS) begin
               add_result(KIND_CANCEL, cid, 32'd0, STAT_INVALID, 1'b0);
            end else if (slot_busy[cid[7:0]] && ver_current[cid[7:0]] == ver &&
                         ver_issued[cid[7:0]] == ver) begin
               ver_current[cid[7:0]] = ver + VERSION_STEP;
               add_result(KIND_CANCEL, cid, 32'd0, STAT_OK, 1'b0);
            end else begin
               add_result(KIND_CANCEL, cid, 32'd0, STAT_NOT_PENDING, 1'b0);
            end
         end
         FUNC_TICK: begin
            while (heap_n > 0) begin
               slot = heap_sl[0];
               ver = ver_issued[slot];
               if (ver_current[slot] != ver) begin
                  heap_remove_top();
                  slot_busy[slot] = 0;
                  continue;
               end
               if (heap_dl[0] > now || fired >= FIRE_LIMIT) break;
               heap_remove_top();
               slot_busy[slot] = 0;
               ver_current[slot] = ver + VERSION_STEP;
               add_result(KIND_FIRED, {ver, 32'(slot)}, slot_tag[slot], STAT_OK, 1'b0);
               fired++;
            end
            if (fired == 0) add_result(KIND_IDLE, 64'd0, 32'd0, STAT_OK, 1'b0);
         end
         default: return;
      endcase
      expected_results[expected_results.size() - 1].last = 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic send_item(logic [1:0] func, logic [62:0] dl, logic [31:0] tag,
                            logic [63:0] cid, logic [62:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {2'b00, now, cid, tag, dl};
      do @(posedge clock); while (!req_tready);
      predict_timer_results(func, dl, tag, cid, now);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_enable(bit value);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      queue_enabled = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic schedule(logic [62:0] dl, logic [31:0] tag);
      send_item(FUNC_SCHEDULE, dl, tag, 64'd0, 63'd0);
   endtask

   task automatic cancel(logic [63:0] cid);
      send_item(FUNC_CANCEL, 63'd0, 32'd0, cid, 63'd0);
   endtask

   task automatic tick(logic [62:0] now);
      send_item(FUNC_TICK, 63'd0, 32'd0, 64'd0, now);
   endtask

   task automatic test_basic();
      logic [63:0] id;
      tick(63'd0);
      schedule(DL_MAX, 32'hFFFF_FFFF);
      schedule(63'd0, 32'd0);
      schedule(63'd0, 32'h1234_5678);
      schedule(63'd5, 32'hA5A5_5A5A);
      id = live_ids[live_ids.size() - 1];
      cancel(id);
      cancel(id);
      cancel({id[63:32] + 32'd2, id[31:0]});
      cancel({32'd0, 32'd300});
      cancel({32'hFFFF_FFFF, 32'hFFFF_FFFF});
      cancel({32'd2, 32'd200});
      send_item(FUNC_UNUSED, DL_MAX, 32'hFFFF_FFFF, {64{1'b1}}, DL_MAX);
      tick(63'd4);
      tick(DL_MAX);
      tick(DL_MAX);
   endtask

   task automatic test_fire_limit();
      for (int i = 0; i < 20; i++) schedule(63'(100 - i % 3), $urandom);
      tick(63'd100);
      tick(63'd100);
   endtask

   task automatic test_disable();
      write_enable(1'b0);
      schedule(63'd10, 32'd7);
      tick(63'd0);
      write_enable(1'b1);
      schedule(63'd10, 32'd7);
      tick(63'd10);
   endtask

   task automatic test_full();
      for (int i = 0; i < SLOTS; i++) schedule(63'(1000 + $urandom_range(0, 50)), $urandom);
      schedule(63'd1, 32'd1);
      cancel(live_ids[live_ids.size() - 1]);
      cancel(live_ids[0]);
      wait_drained();
      while (heap_n > 0) tick(DL_MAX);
   endtask

   task automatic random_item();
      int r;
      logic [63:0] cid;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         if ($urandom_range(0, 9) == 0) schedule(63'({$urandom, $urandom}), $urandom);
         else schedule(sim_now + $urandom_range(0, 400), $urandom);
      end else if (r < 65) begin
         r = $urandom_range(0, 9);
         if (r < 7 && live_ids.size() > 0) begin
            cid = live_ids[$urandom_range(0, live_ids.size() - 1)];
         end else if (r < 9) begin
            cid = {$urandom, 24'd0, 8'($urandom)};
         end else begin
            cid = {$urandom, $urandom};
         end
         cancel(cid);
      end else if (r < 95) begin
         sim_now = sim_now + $urandom_range(0, 200);
         if ($urandom_range(0, 29) == 0) tick(63'({$urandom, $urandom}));
         else tick(sim_now);
      end else begin
         send_item(FUNC_UNUSED, 63'({$urandom, $urandom}), $urandom, {$urandom, $urandom},
                   63'({$urandom, $urandom}));
      end
   endtask

   task automatic test_random();
      for (int i = 0; i < 6; i++) random_item();
      write_enable(1'b0);
      for (int i = 0; i < 3; i++) random_item();
      write_enable(1'b1);
      for (int i = 0; i < 6; i++) random_item();
   endtask

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) rsp_mode <= $urandom_range(0, 2);
      case (rsp_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   always @(posedge clock) begin
      timer_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata[63:0], 64'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("kind", 64'(rsp_tuser), 64'(want.kind));
            if (rsp_tdata[63:0] !== want.id)
               report_mismatch("task_id", rsp_tdata[63:0], want.id);
            if (rsp_tdata[95:64] !== want.tag)
               report_mismatch("tag", 64'(rsp_tdata[95:64]), 64'(want.tag));
            if (rsp_tdata[97:96] !== want.status)
               report_mismatch("status", 64'(rsp_tdata[97:96]), 64'(want.status));
            if (rsp_tdata[98] !== want.earliest)
               report_mismatch("new_earliest", 64'(rsp_tdata[98]), 64'(want.earliest));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
         end
      end
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 2'd0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      rsp_mode = 0;
      error_count = 0;
      sim_now = 63'd1000;
      heap_n = 0;
      queue_enabled = 1;
      for (int i = 0; i < SLOTS; i++) begin
         slot_busy[i] = 0;
         ver_current[i] = VERSION_START;
         ver_issued[i] = '0;
         slot_tag[i] = '0;
         heap_dl[i] = '0;
         heap_sl[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_enable(1'b1);
      test_basic();
      test_fire_limit();
      test_disable();
      test_full();
      test_random();
      wait_drained();
      repeat (100) @(posedge clock);
      if (expected_results.size() > 0)
         report_mismatch("missing items", 64'(expected_results.size()), 64'd0);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
